FILE: hw/rtl/psc_pkg.sv
`timescale 1ns / 1ps
package psc_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int DIV_BITS = 64;

	localparam logic [1:0] REG_TCAL = 2'd0;
	localparam logic [1:0] REG_PCAL_A = 2'd1;
	localparam logic [1:0] REG_PCAL_B = 2'd2;
	localparam logic [1:0] REG_PCAL_C = 2'd3;

	localparam logic [63:0] TFINE_OFFSET = 64'd128000;
	localparam logic [63:0] P_BASE = 64'd1048576;
	localparam logic [63:0] P_SCALE = 64'd3125;
	localparam logic [63:0] P_BIAS = 64'h0000_8000_0000_0000;
	localparam logic [53:0] HPA_RECIP = 54'd171798692;
	localparam logic [13:0] HPA_MAX = 14'd9999;
	localparam logic [28:0] REC1000 = 29'd16778;
	localparam logic [19:0] REC100 = 20'd656;
	localparam logic [13:0] REC10 = 14'd103;

	typedef struct packed {
		logic [47:0] tcal;
		logic [63:0] pcal_a;
		logic [63:0] pcal_b;
		logic [15:0] pcal_c;
	} calib_t;

	typedef struct packed {
		logic signed [31:0] tfine;
		logic [19:0] raw_pressure;
	} front_item_t;

	typedef struct packed {
		logic [QAW:0] count;
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic signed [31:0] tfine;
		logic nz;
	} div_tag_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// low 32x32 partial product
	function automatic logic [63:0] pp_lo(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = {32'd0, a[31:0]} * {32'd0, b[31:0]};
		return r;
	endfunction

	// cross partial products, only the low half survives the wrap
	function automatic logic [31:0] pp_x(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] c1;
		logic [63:0] c2;
		c1 = {32'd0, a[31:0]} * {32'd0, b[63:32]};
		c2 = {32'd0, a[63:32]} * {32'd0, b[31:0]};
		return c1[31:0] + c2[31:0];
	endfunction

	function automatic logic [63:0] pp_join(input logic [63:0] lo, input logic [31:0] x);
		return lo + {x, 32'd0};
	endfunction

endpackage

FILE: hw/rtl/psc_in_if.sv
`timescale 1ns / 1ps
interface psc_in_if;
	logic valid;
	logic ready;
	logic [19:0] raw_pressure;
	logic [19:0] raw_temperature;

	modport source(output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink(input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

FILE: hw/rtl/psc_out_if.sv
`timescale 1ns / 1ps
interface psc_out_if;
	logic valid;
	logic ready;
	logic valid_res;
	logic signed [31:0] fine_temperature;
	logic [31:0] pressure_pa_q8;
	logic [3:0] digit_thousands;
	logic [3:0] digit_hundreds;
	logic [3:0] digit_tens;
	logic [3:0] digit_units;

	modport source(output valid, output valid_res, output fine_temperature,
		output pressure_pa_q8, output digit_thousands, output digit_hundreds,
		output digit_tens, output digit_units, input ready);
	modport sink(input valid, input valid_res, input fine_temperature,
		input pressure_pa_q8, input digit_thousands, input digit_hundreds,
		input digit_tens, input digit_units, output ready);
endinterface

FILE: hw/rtl/psc_front.sv
`timescale 1ns / 1ps
module psc_front import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [47:0] tcal,
	psc_in_if.sink smp,
	input logic push_rdy,
	output logic push_vld,
	output front_item_t push_item
);
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [19:0] adct_s1, adcp_s1, adcp_s2, adcp_s3, adcp_s4;
	logic signed [33:0] ax_s2, dd_s2;
	logic signed [22:0] a_s3;
	logic signed [37:0] bt_s3;
	logic signed [31:0] tf_s4;
	logic signed [17:0] xd;
	logic signed [16:0] dd;
	logic signed [21:0] ddsh;
	logic [15:0] t1;
	logic signed [15:0] t2, t3;

	assign t1 = tcal[15:0];
	assign t2 = $signed(tcal[31:16]);
	assign t3 = $signed(tcal[47:32]);

	assign adv = !vld_s4 || push_rdy;
	assign smp.ready = adv;

	assign xd = $signed({1'b0, adct_s1[19:3]}) - $signed({1'b0, t1, 1'b0});
	assign dd = $signed({1'b0, adct_s1[19:4]}) - $signed({1'b0, t1});
	assign ddsh = dd_s2[33:12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= smp.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adct_s1 <= smp.raw_temperature;
			adcp_s1 <= smp.raw_pressure;
			ax_s2 <= xd * t2;
			dd_s2 <= dd * dd;
			adcp_s2 <= adcp_s1;
			a_s3 <= 23'(ax_s2 >>> 11);
			bt_s3 <= ddsh * t3;
			adcp_s3 <= adcp_s2;
			tf_s4 <= 32'(a_s3) + 32'(bt_s3 >>> 14);
			adcp_s4 <= adcp_s3;
		end
	end

	assign push_vld = vld_s4;
	assign push_item.tfine = tf_s4;
	assign push_item.raw_pressure = adcp_s4;
endmodule

FILE: hw/rtl/psc_queue.sv
`timescale 1ns / 1ps
module psc_queue import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push_vld,
	input front_item_t push_item,
	output logic push_rdy,
	input logic pop,
	output logic pop_vld,
	output front_item_t pop_item,
	output qstat_t stat
);
	front_item_t mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0] count_q;
	logic do_push, do_pop;

	assign push_rdy = count_q != (QAW+1)'(QDEPTH);
	assign pop_vld = count_q != '0;
	assign do_push = push_vld && push_rdy;
	assign do_pop = pop && pop_vld;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) wptr_q <= wptr_q + 1'b1;
			if (do_pop) rptr_q <= rptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_item;
	end

	assign stat.count = count_q;
	assign stat.full = !push_rdy;
	assign stat.empty = !pop_vld;
endmodule

FILE: hw/rtl/psc_div.sv
`timescale 1ns / 1ps
module psc_div import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [63:0] num,
	input logic [63:0] den,
	input div_tag_t in_tag,
	output logic out_vld,
	output logic [63:0] quot,
	output div_tag_t out_tag
);
	logic vld_s [DIV_BITS+1];
	logic [63:0] rem_s [DIV_BITS+1];
	logic [63:0] nq_s [DIV_BITS+1];
	logic [63:0] den_s [DIV_BITS+1];
	logic neg_s [DIV_BITS+1];
	div_tag_t tag_s [DIV_BITS+1];
	logic vld_q;
	logic [63:0] quot_q;
	div_tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
			vld_q <= vld_s[DIV_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			nq_s[0] <= num[63] ? -num : num;
			den_s[0] <= den[63] ? -den : den;
			neg_s[0] <= num[63] ^ den[63];
			tag_s[0] <= in_tag;
			quot_q <= neg_s[DIV_BITS] ? -nq_s[DIV_BITS] : nq_s[DIV_BITS];
			tag_q <= tag_s[DIV_BITS];
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_step
		logic [64:0] trial;
		logic take;

		assign trial = {rem_s[k], nq_s[k][63]};
		assign take = trial >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? 64'(trial - {1'b0, den_s[k]}) : trial[63:0];
				nq_s[k+1] <= {nq_s[k][62:0], take};
				den_s[k+1] <= den_s[k];
				neg_s[k+1] <= neg_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign out_vld = vld_q;
	assign quot = quot_q;
	assign out_tag = tag_q;
endmodule

FILE: hw/rtl/psc_back.sv
`timescale 1ns / 1ps
module psc_back import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input calib_t calib,
	input logic in_vld,
	input front_item_t in_item,
	output logic pop,
	psc_out_if.source res
);
	logic adv;
	logic [8:0] vld_a_q;
	logic [14:0] vld_b_q;
	logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

	logic [63:0] v1_s1;
	logic [19:0] adcp_s1, adcp_s2, adcp_s3, adcp_s4, adcp_s5, adcp_s6;
	logic signed [31:0] tf_s1, tf_s2, tf_s3, tf_s4, tf_s5, tf_s6, tf_s7, tf_s8, tf_s9;
	logic [63:0] sqlo_s2, m5lo_s2, m2lo_s2;
	logic [31:0] sqx_s2, m5x_s2, m2x_s2;
	logic [63:0] sq_s3, m5_s3, m2_s3;
	logic [63:0] a6lo_s4, a3lo_s4, m5_s4, m2_s4;
	logic [31:0] a6x_s4, a3x_s4;
	logic [63:0] a6_s5, a3_s5, m5_s5, m2_s5;
	logic [63:0] v2_s6, u_s6;
	logic [63:0] x_s7, base_s7;
	logic [63:0] wlo_s8, nlo_s8;
	logic [31:0] wx_s8, nx_s8;
	logic [63:0] w_s9, n_s9;

	logic [63:0] den;
	div_tag_t dtag;
	logic dvld;
	logic [63:0] dq;
	div_tag_t dq_tag;
	logic [63:0] sdq;

	div_tag_t tag_e1, tag_e2, tag_e3, tag_e4, tag_e5, tag_e6, tag_e7, tag_e8;
	div_tag_t tag_e9, tag_e10, tag_e11, tag_e12, tag_e13, tag_e14, tag_e15;
	logic [63:0] sslo_e1, m8lo_e1, p_e1;
	logic [31:0] ssx_e1, m8x_e1;
	logic [63:0] ss_e2, m8_e2, p_e2;
	logic [63:0] w1lo_e3, w2_e3, p_e3;
	logic [31:0] w1x_e3;
	logic [63:0] w1_e4, w2_e4, p_e4, w1j;
	logic [63:0] sum_e5, pf_e6;
	logic [31:0] pres_e7, pres_e8, pres_e9, pres_e10, pres_e11, pres_e12;
	logic [31:0] pres_e13, pres_e14, pres_e15;
	logic [53:0] hq_e8;
	logic [13:0] hpa_e9, hpa_e10;
	logic [3:0] th_e10, th_e11, th_e12, th_e13, th_e14, th_e15;
	logic [9:0] r1_e11, r1_e12;
	logic [3:0] hu_e12, hu_e13, hu_e14, hu_e15;
	logic [6:0] r2_e13, r2_e14;
	logic [3:0] te_e14, te_e15;
	logic [3:0] un_e15;
	logic [21:0] hq_hi;

	assign p1 = {48'd0, calib.pcal_a[15:0]};
	assign p2 = sx16(calib.pcal_a[31:16]);
	assign p3 = sx16(calib.pcal_a[47:32]);
	assign p4 = sx16(calib.pcal_a[63:48]);
	assign p5 = sx16(calib.pcal_b[15:0]);
	assign p6 = sx16(calib.pcal_b[31:16]);
	assign p7 = sx16(calib.pcal_b[47:32]);
	assign p8 = sx16(calib.pcal_b[63:48]);
	assign p9 = sx16(calib.pcal_c);

	assign adv = res.ready || !vld_b_q[14];
	assign pop = adv;

	assign den = 64'($signed(w_s9) >>> 33);
	assign dtag.tfine = tf_s9;
	assign dtag.nz = den != '0;
	assign sdq = 64'($signed(dq) >>> 13);
	assign w1j = pp_join(w1lo_e3, w1x_e3);
	assign hq_hi = hq_e8[53:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_q <= '0;
			vld_b_q <= '0;
		end else if (adv) begin
			vld_a_q <= {vld_a_q[7:0], in_vld};
			vld_b_q <= {vld_b_q[13:0], dvld};
		end
	end

	psc_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(adv),
		.in_vld(vld_a_q[8]),
		.num(n_s9),
		.den(den),
		.in_tag(dtag),
		.out_vld(dvld),
		.quot(dq),
		.out_tag(dq_tag)
	);

	// pressure terms up to the divider
	always_ff @(posedge clk) begin
		if (adv) begin
			v1_s1 <= {{32{in_item.tfine[31]}}, in_item.tfine} - TFINE_OFFSET;
			adcp_s1 <= in_item.raw_pressure;
			tf_s1 <= in_item.tfine;

			sqlo_s2 <= pp_lo(v1_s1, v1_s1);
			sqx_s2 <= pp_x(v1_s1, v1_s1);
			m5lo_s2 <= pp_lo(v1_s1, p5);
			m5x_s2 <= pp_x(v1_s1, p5);
			m2lo_s2 <= pp_lo(v1_s1, p2);
			m2x_s2 <= pp_x(v1_s1, p2);
			adcp_s2 <= adcp_s1;
			tf_s2 <= tf_s1;

			sq_s3 <= pp_join(sqlo_s2, sqx_s2);
			m5_s3 <= pp_join(m5lo_s2, m5x_s2);
			m2_s3 <= pp_join(m2lo_s2, m2x_s2);
			adcp_s3 <= adcp_s2;
			tf_s3 <= tf_s2;

			a6lo_s4 <= pp_lo(sq_s3, p6);
			a6x_s4 <= pp_x(sq_s3, p6);
			a3lo_s4 <= pp_lo(sq_s3, p3);
			a3x_s4 <= pp_x(sq_s3, p3);
			m5_s4 <= m5_s3;
			m2_s4 <= m2_s3;
			adcp_s4 <= adcp_s3;
			tf_s4 <= tf_s3;

			a6_s5 <= pp_join(a6lo_s4, a6x_s4);
			a3_s5 <= pp_join(a3lo_s4, a3x_s4);
			m5_s5 <= m5_s4;
			m2_s5 <= m2_s4;
			adcp_s5 <= adcp_s4;
			tf_s5 <= tf_s4;

			v2_s6 <= a6_s5 + (m5_s5 << 17) + (p4 << 35);
			u_s6 <= 64'($signed(a3_s5) >>> 8) + (m2_s5 << 12);
			adcp_s6 <= adcp_s5;
			tf_s6 <= tf_s5;

			x_s7 <= P_BIAS + u_s6;
			base_s7 <= ((P_BASE - {44'd0, adcp_s6}) << 31) - v2_s6;
			tf_s7 <= tf_s6;

			wlo_s8 <= pp_lo(x_s7, p1);
			wx_s8 <= pp_x(x_s7, p1);
			nlo_s8 <= pp_lo(base_s7, P_SCALE);
			nx_s8 <= pp_x(base_s7, P_SCALE);
			tf_s8 <= tf_s7;

			w_s9 <= pp_join(wlo_s8, wx_s8);
			n_s9 <= pp_join(nlo_s8, nx_s8);
			tf_s9 <= tf_s8;
		end
	end

	// correction, saturation and decimal split
	always_ff @(posedge clk) begin
		if (adv) begin
			sslo_e1 <= pp_lo(sdq, sdq);
			ssx_e1 <= pp_x(sdq, sdq);
			m8lo_e1 <= pp_lo(p8, dq);
			m8x_e1 <= pp_x(p8, dq);
			p_e1 <= dq;
			tag_e1 <= dq_tag;

			ss_e2 <= pp_join(sslo_e1, ssx_e1);
			m8_e2 <= pp_join(m8lo_e1, m8x_e1);
			p_e2 <= p_e1;
			tag_e2 <= tag_e1;

			w1lo_e3 <= pp_lo(p9, ss_e2);
			w1x_e3 <= pp_x(p9, ss_e2);
			w2_e3 <= 64'($signed(m8_e2) >>> 19);
			p_e3 <= p_e2;
			tag_e3 <= tag_e2;

			w1_e4 <= 64'($signed(w1j) >>> 25);
			w2_e4 <= w2_e3;
			p_e4 <= p_e3;
			tag_e4 <= tag_e3;

			sum_e5 <= p_e4 + w1_e4 + w2_e4;
			tag_e5 <= tag_e4;

			pf_e6 <= 64'($signed(sum_e5) >>> 8) + (p7 << 4);
			tag_e6 <= tag_e5;

			if (!tag_e6.nz || pf_e6[63]) pres_e7 <= '0;
			else if (pf_e6[62:32] != '0) pres_e7 <= '1;
			else pres_e7 <= pf_e6[31:0];
			tag_e7 <= tag_e6;

			hq_e8 <= 54'(pres_e7[31:10]) * HPA_RECIP;
			pres_e8 <= pres_e7;
			tag_e8 <= tag_e7;

			hpa_e9 <= (hq_hi > 22'(HPA_MAX)) ? HPA_MAX : hq_hi[13:0];
			pres_e9 <= pres_e8;
			tag_e9 <= tag_e8;

			th_e10 <= 4'((29'(hpa_e9) * REC1000) >> 24);
			hpa_e10 <= hpa_e9;
			pres_e10 <= pres_e9;
			tag_e10 <= tag_e9;

			r1_e11 <= 10'(hpa_e10 - 14'(th_e10) * 14'd1000);
			th_e11 <= th_e10;
			pres_e11 <= pres_e10;
			tag_e11 <= tag_e10;

			hu_e12 <= 4'((20'(r1_e11) * REC100) >> 16);
			r1_e12 <= r1_e11;
			th_e12 <= th_e11;
			pres_e12 <= pres_e11;
			tag_e12 <= tag_e11;

			r2_e13 <= 7'(r1_e12 - 10'(hu_e12) * 10'd100);
			hu_e13 <= hu_e12;
			th_e13 <= th_e12;
			pres_e13 <= pres_e12;
			tag_e13 <= tag_e12;

			te_e14 <= 4'((14'(r2_e13) * REC10) >> 10);
			r2_e14 <= r2_e13;
			hu_e14 <= hu_e13;
			th_e14 <= th_e13;
			pres_e14 <= pres_e13;
			tag_e14 <= tag_e13;

			un_e15 <= 4'(r2_e14 - 7'(te_e14) * 7'd10);
			te_e15 <= te_e14;
			hu_e15 <= hu_e14;
			th_e15 <= th_e14;
			pres_e15 <= pres_e14;
			tag_e15 <= tag_e14;
		end
	end

	assign res.valid = vld_b_q[14];
	assign res.valid_res = tag_e15.nz;
	assign res.fine_temperature = tag_e15.tfine;
	assign res.pressure_pa_q8 = pres_e15;
	assign res.digit_thousands = th_e15;
	assign res.digit_hundreds = hu_e15;
	assign res.digit_tens = te_e15;
	assign res.digit_units = un_e15;
endmodule

FILE: hw/rtl/pressure_sensor_compensation.sv
`timescale 1ns / 1ps
// Integer compensation of raw barometer samples.
// sample: valid/ready request carrying a 20-bit raw pressure and a 20-bit raw
//   temperature; taken on a clock edge with valid and ready both high.
// result: valid/ready request with valid_res, fine temperature, pressure in
//   Pa times 256 and the four decimal digits of whole hPa.
// cfg_we/cfg_index/cfg_data write the four calibration registers; write them
//   only while no request is in flight.
// From sample acceptance to result the path runs through 4 temperature
//   stages, the queue, 9 pressure stages, a 66-stage one bit per stage
//   signed divider and 15 correction and digit stages.
// Throughput is one request per cycle while the receiver keeps ready high; every stage is pipelined.
// A 4-entry queue separates the temperature front end from the pressure
//   back end. When the receiver holds ready low the back end freezes, the
//   queue fills, then the front end freezes and sample.ready falls.
// Reset clears all calibration registers and drops every request in flight.
module pressure_sensor_compensation import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	psc_in_if.sink sample,
	psc_out_if.source result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data
);
	calib_t calib_q;
	logic push_vld, push_rdy, pop, pop_vld;
	front_item_t push_item, pop_item;
	qstat_t qstat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TCAL: calib_q.tcal <= cfg_data[47:0];
				REG_PCAL_A: calib_q.pcal_a <= cfg_data;
				REG_PCAL_B: calib_q.pcal_b <= cfg_data;
				REG_PCAL_C: calib_q.pcal_c <= cfg_data[15:0];
				default: calib_q <= calib_q;
			endcase
		end
	end

	psc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.tcal(calib_q.tcal),
		.smp(sample),
		.push_rdy(push_rdy),
		.push_vld(push_vld),
		.push_item(push_item)
	);

	psc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_vld(push_vld),
		.push_item(push_item),
		.push_rdy(push_rdy),
		.pop(pop),
		.pop_vld(pop_vld),
		.pop_item(pop_item),
		.stat(qstat)
	);

	psc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.calib(calib_q),
		.in_vld(pop_vld),
		.in_item(pop_item),
		.pop(pop),
		.res(result)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.count <= (QAW+1)'(QDEPTH) && !(qstat.full && qstat.empty))
		else $error("queue count out of range");

	a_queue_step: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.full |=> !qstat.empty)
		else $error("full queue emptied in one cycle");

	a_zero_div: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.valid_res |-> result.pressure_pa_q8 == '0 &&
		result.digit_thousands == '0 && result.digit_hundreds == '0 &&
		result.digit_tens == '0 && result.digit_units == '0)
		else $error("zero divisor result carries data");

	a_digits: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.digit_thousands <= 4'd9 && result.digit_hundreds <= 4'd9 &&
		result.digit_tens <= 4'd9 && result.digit_units <= 4'd9)
		else $error("digit out of range");
endmodule

FILE: tb/sv/psc_checker.sv
`timescale 1ns / 1ps
module psc_checker import psc_pkg::*; (
	input logic clk,
	input logic arst_n,
	psc_in_if sample,
	psc_out_if result,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [63:0] cfg_data,
	output int fail_count,
	output int pending,
	output int result_count,
	output int invalid_count
);

	typedef struct packed {
		logic valid_res;
		logic signed [31:0] fine_temperature;
		logic [31:0] pressure_pa_q8;
		logic [3:0] thousands;
		logic [3:0] hundreds;
		logic [3:0] tens;
		logic [3:0] units;
	} reading_t;

	logic [47:0] tcal;
	logic [63:0] pcal_a;
	logic [63:0] pcal_b;
	logic [15:0] pcal_c;
	reading_t expected_readings[$];

	function automatic logic signed [63:0] s16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	function automatic reading_t compensate(input logic [19:0] raw_p, input logic [19:0] raw_t);
		logic signed [63:0] adc_p, adc_t, t1, t2, t3, a, d, b, tfine;
		logic signed [63:0] v1, v2, p, s, w1, w2, num, q;
		logic [63:0] un, ud, uq, pres, hpa;
		reading_t r;
		adc_p = $signed({44'd0, raw_p});
		adc_t = $signed({44'd0, raw_t});
		t1 = $signed({48'd0, tcal[15:0]});
		t2 = s16(tcal[31:16]);
		t3 = s16(tcal[47:32]);
		a = (((adc_t >>> 3) - t1 * 2) * t2) >>> 11;
		d = (adc_t >>> 4) - t1;
		b = (((d * d) >>> 12) * t3) >>> 14;
		tfine = a + b;
		v1 = tfine - 64'sd128000;
		v2 = v1 * v1 * s16(pcal_b[31:16]);
		v2 = v2 + ((v1 * s16(pcal_b[15:0])) <<< 17);
		v2 = v2 + (s16(pcal_a[63:48]) <<< 35);
		v1 = ((v1 * v1 * s16(pcal_a[47:32])) >>> 8) + ((v1 * s16(pcal_a[31:16])) <<< 12);
		v1 = (((64'sd1 <<< 47) + v1) * $signed({48'd0, pcal_a[15:0]})) >>> 33;
		r = '0;
		r.fine_temperature = tfine[31:0];
		if (v1 != 0) begin
			p = 64'sd1048576 - adc_p;
			num = ((p <<< 31) - v2) * 64'sd3125;
			un = num[63] ? -num : num;
			ud = v1[63] ? -v1 : v1;
			uq = un / ud;
			q = (num[63] != v1[63]) ? -uq : uq;
			p = q;
			s = p >>> 13;
			w1 = (s16(pcal_c) * s * s) >>> 25;
			w2 = (s16(pcal_b[63:48]) * p) >>> 19;
			p = ((p + w1 + w2) >>> 8) + (s16(pcal_b[47:32]) <<< 4);
			if (p[63]) pres = 64'd0;
			else if (p > 64'sd4294967295) pres = 64'hFFFF_FFFF;
			else pres = p;
			hpa = pres / 64'd25600;
			if (hpa > 64'd9999) hpa = 64'd9999;
			r.valid_res = 1'b1;
			r.pressure_pa_q8 = pres[31:0];
			r.thousands = 4'(hpa / 64'd1000);
			r.hundreds = 4'((hpa / 64'd100) % 64'd10);
			r.tens = 4'((hpa / 64'd10) % 64'd10);
			r.units = 4'(hpa % 64'd10);
		end
		return r;
	endfunction

	assign pending = expected_readings.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t e;
		if (!arst_n) begin
			tcal <= '0;
			pcal_a <= '0;
			pcal_b <= '0;
			pcal_c <= '0;
			expected_readings.delete();
			fail_count <= 0;
			result_count <= 0;
			invalid_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TCAL: begin
						tcal <= cfg_data[47:0];
					end
					REG_PCAL_A: begin
						pcal_a <= cfg_data;
					end
					REG_PCAL_B: begin
						pcal_b <= cfg_data;
					end
					REG_PCAL_C: begin
						pcal_c <= cfg_data[15:0];
					end
					default: begin
					end
				endcase
			end
			if (sample.valid && sample.ready)
				expected_readings.push_back(compensate(sample.raw_pressure, sample.raw_temperature));
			if (result.valid && result.ready) begin
				result_count <= result_count + 1;
				if (expected_readings.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_readings.pop_front();
					if (!e.valid_res) invalid_count <= invalid_count + 1;
					if (e != {result.valid_res, result.fine_temperature, result.pressure_pa_q8,
						result.digit_thousands, result.digit_hundreds, result.digit_tens,
						result.digit_units}) begin
						fail_count <= fail_count + 1;
						if (e.valid_res != result.valid_res)
							$error("valid_res exp %0d got %0d", e.valid_res, result.valid_res);
						if (e.fine_temperature != result.fine_temperature)
							$error("fine_temperature exp %0d got %0d", e.fine_temperature,
								result.fine_temperature);
						if (e.pressure_pa_q8 != result.pressure_pa_q8)
							$error("pressure_pa_q8 exp %0d got %0d", e.pressure_pa_q8,
								result.pressure_pa_q8);
						if (e.thousands != result.digit_thousands)
							$error("digit_thousands exp %0d got %0d", e.thousands,
								result.digit_thousands);
						if (e.hundreds != result.digit_hundreds)
							$error("digit_hundreds exp %0d got %0d", e.hundreds,
								result.digit_hundreds);
						if (e.tens != result.digit_tens)
							$error("digit_tens exp %0d got %0d", e.tens, result.digit_tens);
						if (e.units != result.digit_units)
							$error("digit_units exp %0d got %0d", e.units, result.digit_units);
					end
				end
			end
		end
	end

endmodule

FILE: tb/sv/pressure_sensor_compensation_tb.sv
`timescale 1ns / 1ps
module pressure_sensor_compensation_tb import psc_pkg::*;;

	localparam int LATENCY = 95;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_TCAL;
	logic [63:0] cfg_data = '0;
	int fail_count, pending, result_count, invalid_count;
	int sent_count = 0;
	int gap_left = 0;
	int burst_left = 0;
	int stall_mode = 0;

	psc_in_if sample();
	psc_out_if result();

	pressure_sensor_compensation u_top (
		.clk(clk), .arst_n(arst_n), .sample(sample.sink), .result(result.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	psc_checker u_checker (
		.clk(clk), .arst_n(arst_n), .sample(sample), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending), .result_count(result_count),
		.invalid_count(invalid_count)
	);

	always #10 clk = ~clk;

	// receiver stall pattern, mode switches at random
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: result.ready <= 1'b1;
			1: result.ready <= ($urandom_range(0, 3) != 0);
			2: result.ready <= ($urandom_range(0, 1) != 0);
			default: result.ready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pa,
		input logic [63:0] pb, input logic [15:0] pc);
		write_reg(REG_TCAL, {16'd0, tc});
		write_reg(REG_PCAL_A, pa);
		write_reg(REG_PCAL_B, pb);
		write_reg(REG_PCAL_C, {48'd0, pc});
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// one request with burst/gap shaped idling
	task automatic send(input logic [19:0] rp, input logic [19:0] rt);
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_left != 0) begin
				sample.valid <= 1'b0;
				repeat (gap_left) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		sample.valid <= 1'b1;
		sample.raw_pressure <= rp;
		sample.raw_temperature <= rt;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		burst_left--;
		sent_count++;
	endtask

	task automatic idle_input();
		sample.valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic random_calibration(input int flavor);
		logic [47:0] tc;
		logic [63:0] pa, pb;
		logic [15:0] pc;
		if (flavor == 0) begin
			// typical factory words with jitter
			tc = {16'd50 + 16'($urandom_range(0, 100)), 16'd26000 + 16'($urandom_range(0, 1000)),
				16'd27000 + 16'($urandom_range(0, 1000))};
			pa = {16'd2900 + 16'($urandom_range(0, 200)), -16'sd4000 - 16'($urandom_range(0, 500)),
				-16'sd10500 + 16'($urandom_range(0, 500)), 16'd36000 + 16'($urandom_range(0, 2000))};
			pb = {16'd3000 + 16'($urandom_range(0, 1000)), 16'd15500 + 16'($urandom_range(0, 200)),
				-16'sd7 - 16'($urandom_range(0, 2)), 16'd100 + 16'($urandom_range(0, 200))};
			pc = 16'd4000 + 16'($urandom_range(0, 2000));
		end else begin
			tc = 48'({$urandom, $urandom});
			pa = {$urandom, $urandom};
			pb = {$urandom, $urandom};
			pc = 16'($urandom);
			if ($urandom_range(0, 3) == 0) pa[15:0] = 16'd0;
		end
		load_calibration(tc, pa, pb, pc);
	endtask

	initial begin
		sample.valid = 1'b0;
		sample.raw_pressure = '0;
		sample.raw_temperature = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset calibration: divisor zero
		send(20'd0, 20'd0);
		send(20'hFFFFF, 20'hFFFFF);
		idle_input();
		drain();
		// typical words, then field extremes
		load_calibration({16'hD00C, 16'h6A6B, 16'd27504}, {16'h0B8B, 16'hD6A9, 16'hF1C5, 16'd36477},
			{16'hFFF9, 16'hE78A, 16'h00D7, 16'hFFF9}, 16'hFB9D);
		send(20'd0, 20'd0);
		send(20'hFFFFF, 20'd0);
		send(20'd0, 20'hFFFFF);
		send(20'hFFFFF, 20'hFFFFF);
		send(20'd415148, 20'd519888);
		send(20'h55555, 20'hAAAAA);
		send(20'hAAAAA, 20'h55555);
		send(20'd1, 20'd1);
		idle_input();
		drain();
		// all-ones and extreme signed words
		load_calibration('1, '1, '1, '1);
		send(20'd0, 20'hFFFFF);
		send(20'hFFFFF, 20'd0);
		idle_input();
		drain();
		load_calibration({16'h8000, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF},
			{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 16'h8000);
		send(20'd0, 20'd0);
		send(20'hFFFFF, 20'hFFFFF);
		send(20'd300000, 20'd600000);
		idle_input();
		drain();
		// random phases
		for (int ph = 0; ph < 16; ph++) begin
			random_calibration((ph % 3 == 2) ? 1 : 0);
			for (int i = 0; i < 96; i++) begin
				if ($urandom_range(0, 3) == 0)
					send(20'($urandom), 20'($urandom));
				else
					send(20'd350000 + 20'($urandom_range(0, 300000)),
						20'd480000 + 20'($urandom_range(0, 100000)));
				if (i == 48 && ph == 5) begin
					idle_input();
					@(posedge clk);
					while (pending != 0) @(posedge clk);
				end
			end
			idle_input();
			drain();
		end
		$display("sent %0d samples over 20 calibration sets, %0d results checked (%0d divisor zero)",
			sent_count, result_count, invalid_count);
		if (fail_count == 0)
			$display("** pressure_sensor_compensation: PASSED **");
		else
			$display("** pressure_sensor_compensation: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** pressure_sensor_compensation: FAILED **");
		$finish;
	end

endmodule
